// ----- sv/pi_pkg.sv -----
// pi_pkg: shared types and codes for the partition individualisation block.
// No dependencies; imported by pi_cell, pi_feed and partition_individualize.
package pi_pkg;

  localparam int MAX_ELEMS = 32;
  localparam int IDX_W     = 5;
  localparam int LEN_W     = 6;
  localparam int TAKE_W    = 2;

  typedef struct packed {
    logic [IDX_W-1:0] start;
    logic [LEN_W-1:0] length;
  } entry_t;

  typedef enum logic [1:0] {
    ACT_RESTART = 2'd0,
    ACT_ONE     = 2'd1,
    ACT_TWO     = 2'd2,
    ACT_NOP     = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_RANGE = 2'd1,
    ERR_PAIR  = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    PK_RESTART,
    PK_KEEP,
    PK_SPLIT,
    PK_CHECK
  } pass_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PASS,
    ST_ERR
  } state_t;

  // what the feed stage needs to know about the running pass
  typedef struct packed {
    pass_kind_t        kind;
    logic [IDX_W-1:0]  t;
    logic [IDX_W-1:0]  c;
    logic [TAKE_W-1:0] take;
  } pass_ctl_t;

endpackage

// ----- sv/pi_cell.sv -----
// pi_cell: one cell of the class-table ring, holds one start/length entry.
// Depends on pi_pkg.
module pi_cell (
  input  logic          clk,
  input  logic          rst,
  input  pi_pkg::entry_t rst_val,
  input  logic          en,
  input  pi_pkg::entry_t d,
  output pi_pkg::entry_t q
);
  import pi_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= rst_val;
    end else if (en) begin
      q <= d;
    end
  end

endmodule

// ----- sv/pi_feed.sv -----
// pi_feed: rewrites the entry leaving the ring tail into the entry fed back
// at the ring head, restarting the table or splitting one class per pass. Depends on pi_pkg.
module pi_feed (
  input  logic             clk,
  input  logic             step,
  input  pi_pkg::pass_ctl_t ctl,
  input  pi_pkg::entry_t    tail,
  input  logic [pi_pkg::LEN_W-1:0] n,
  output pi_pkg::entry_t    feed,
  output logic             splitting
);
  import pi_pkg::*;

  entry_t d1;
  logic   split_reg;
  logic   at_c;
  logic   cuts;

  assign at_c = (ctl.t == ctl.c);
  assign cuts = (tail.length > LEN_W'(ctl.take));
  assign splitting = at_c ? cuts : split_reg;

  always_comb begin
    feed = tail;
    unique case (ctl.kind)
      PK_RESTART: begin
        if (ctl.t == '0) begin
          feed.start  = '0;
          feed.length = n;
        end
      end
      PK_SPLIT: begin
        if (at_c && cuts) begin
          feed.start  = tail.start;
          feed.length = LEN_W'(ctl.take);
        end else if ((ctl.t > ctl.c) && split_reg) begin
          if (ctl.t == IDX_W'(ctl.c + IDX_W'(1))) begin
            feed.start  = IDX_W'(d1.start + IDX_W'(ctl.take));
            feed.length = LEN_W'(d1.length - LEN_W'(ctl.take));
          end else begin
            feed = d1;
          end
        end
      end
      default: feed = tail;
    endcase
  end

  always_ff @(posedge clk) begin
    if (step) begin
      d1 <= tail;
      if (at_c) begin
        split_reg <= cuts;
      end
    end
  end

endmodule

// ----- sv/partition_individualize.sv -----
// Ordered partition individualisation.
// Classes live in a ring of 32 cells; each pass rotates the ring once,
// rewriting entries through pi_feed. Depends on pi_pkg, pi_cell, pi_feed.
//
// Use:
//   s_*   : input word. tuser = action, tdata = class_a, class_b.
//   m_*   : result word, one per class in class order; tlast on the final one,
//           tuser = error code. An error gives one all-zero word with tlast.
//   cfg_* : writes element_count, used by the next restart; write only while idle.
// Timing:
//   An item takes one ring pass (restart, one class, unused action)
//   or two passes (two classes, or a pair check then the split).
//   A word is taken only while idle, so the next item waits until its passes end.
//   Results are sent during the last pass.
//   An out-of-range class index is answered from the error state, with no ring pass.
//   The ring rotation is the limit: one cell shift per cycle while the ring is not held.
// Stall: while a result is due, the result register is full and m_tready is low, the ring holds.
//   A new word is taken as soon as the pass ends, the last result may still wait.
// Reset: one class of 32 elements, element_count 32, result register empty.
module partition_individualize (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // class_a[4:0], class_b[9:5], zero
  input  logic [1:0]  s_tuser,   // action[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // class_index[4:0], class_start[9:5], class_length[15:10]
  output logic [1:0]  m_tuser,   // error[1:0]
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data
);
  import pi_pkg::*;

  localparam logic [IDX_W-1:0] T_END = IDX_W'(MAX_ELEMS - 1);

  state_t            state, state_next;
  pass_kind_t        kind, kind_next;
  logic              emit, emit_next;
  logic [IDX_W-1:0]  t, t_next;
  logic [IDX_W-1:0]  c, c_next;
  logic [TAKE_W-1:0] take, take_next;
  logic              second_pending, second_pending_next;
  logic [IDX_W-1:0]  second_c, second_c_next;
  err_t              err_code, err_code_next;
  logic              pair_short, pair_short_next;
  logic [LEN_W-1:0]  count, count_next;
  logic [LEN_W-1:0]  elem_cfg;
  logic [LEN_W-1:0]  n_eff;

  act_t              act;
  logic [IDX_W-1:0]  a_in, b_in;

  entry_t            q [MAX_ELEMS];
  entry_t            tail, feed;
  pass_ctl_t         ctl;
  logic              splitting;
  logic              step;
  logic              emit_now;
  logic              out_free;
  logic [LEN_W-1:0]  ncnt;
  logic              is_last;
  logic              load_word, load_err;

  entry_t            out_entry;
  logic [IDX_W-1:0]  out_index;
  err_t              out_err;
  logic              out_last;

  assign act  = act_t'(s_tuser);
  assign a_in = s_tdata[4:0];
  assign b_in = s_tdata[9:5];

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      elem_cfg <= LEN_W'(MAX_ELEMS);
    end else if (cfg_valid) begin
      elem_cfg <= cfg_data;
    end
  end

  always_comb begin
    if (elem_cfg == '0) begin
      n_eff = LEN_W'(1);
    end else if (elem_cfg > LEN_W'(MAX_ELEMS)) begin
      n_eff = LEN_W'(MAX_ELEMS);
    end else begin
      n_eff = elem_cfg;
    end
  end

  // ring: entry i sits in cell MAX_ELEMS-1-i between passes
  genvar k;
  generate
    for (k = 0; k < MAX_ELEMS; k++) begin : g_ring
      entry_t rv;
      entry_t dk;
      assign rv.start  = '0;
      assign rv.length = (k == MAX_ELEMS - 1) ? LEN_W'(MAX_ELEMS) : '0;
      if (k == 0) begin : g_head
        assign dk = feed;
      end else begin : g_body
        assign dk = q[k-1];
      end
      pi_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .rst_val (rv),
        .en      (step),
        .d       (dk),
        .q       (q[k])
      );
    end
  endgenerate

  assign tail = q[MAX_ELEMS-1];

  assign ctl.kind = kind;
  assign ctl.t    = t;
  assign ctl.c    = c;
  assign ctl.take = take;

  pi_feed u_feed (
    .clk       (clk),
    .step      (step),
    .ctl       (ctl),
    .tail      (tail),
    .n         (n_eff),
    .feed      (feed),
    .splitting (splitting)
  );

  always_comb begin
    unique case (kind)
      PK_RESTART: ncnt = LEN_W'(1);
      PK_SPLIT:   ncnt = count + LEN_W'((t >= c) && splitting);
      default:    ncnt = count;
    endcase
  end

  assign out_free  = !m_tvalid || m_tready;
  assign emit_now  = (state == ST_PASS) && emit && ({1'b0, t} < ncnt);
  assign step      = (state == ST_PASS) && (!emit_now || out_free);
  assign is_last   = ({1'b0, t} == LEN_W'(ncnt - LEN_W'(1)));
  assign load_word = step && emit_now;
  assign load_err  = (state == ST_ERR) && out_free;
  assign s_tready  = (state == ST_IDLE);

  always_comb begin
    state_next          = state;
    kind_next           = kind;
    emit_next           = emit;
    t_next              = t;
    c_next              = c;
    take_next           = take;
    second_pending_next = second_pending;
    second_c_next       = second_c;
    err_code_next       = err_code;
    pair_short_next     = pair_short;
    count_next          = count;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          t_next              = '0;
          take_next           = TAKE_W'(1);
          second_pending_next = 1'b0;
          unique case (act)
            ACT_RESTART: begin
              kind_next  = PK_RESTART;
              emit_next  = 1'b1;
              state_next = ST_PASS;
            end
            ACT_ONE: begin
              if ({1'b0, a_in} >= count) begin
                err_code_next = ERR_RANGE;
                state_next    = ST_ERR;
              end else begin
                kind_next  = PK_SPLIT;
                c_next     = a_in;
                emit_next  = 1'b1;
                state_next = ST_PASS;
              end
            end
            ACT_TWO: begin
              if (({1'b0, a_in} >= count) || ({1'b0, b_in} >= count)) begin
                err_code_next = ERR_RANGE;
                state_next    = ST_ERR;
              end else if (a_in == b_in) begin
                kind_next  = PK_CHECK;
                c_next     = a_in;
                emit_next  = 1'b0;
                state_next = ST_PASS;
              end else begin
                // higher class first so the lower index still holds
                kind_next           = PK_SPLIT;
                c_next              = (a_in > b_in) ? a_in : b_in;
                second_c_next       = (a_in > b_in) ? b_in : a_in;
                second_pending_next = 1'b1;
                emit_next           = 1'b0;
                state_next          = ST_PASS;
              end
            end
            default: begin
              kind_next  = PK_KEEP;
              emit_next  = 1'b1;
              state_next = ST_PASS;
            end
          endcase
        end
      end
      ST_PASS: begin
        if (step) begin
          t_next = IDX_W'(t + IDX_W'(1));
          if ((kind == PK_CHECK) && (t == c)) begin
            pair_short_next = (tail.length < LEN_W'(2));
          end
          if (t == T_END) begin
            if (kind == PK_RESTART) begin
              count_next = LEN_W'(1);
            end else if (kind == PK_SPLIT) begin
              count_next = count + LEN_W'(splitting);
            end
            if (kind == PK_CHECK) begin
              if (pair_short_next) begin
                err_code_next = ERR_PAIR;
                state_next    = ST_ERR;
              end else begin
                kind_next = PK_SPLIT;
                take_next = TAKE_W'(2);
                emit_next = 1'b1;
              end
            end else if (second_pending) begin
              kind_next           = PK_SPLIT;
              c_next              = second_c;
              take_next           = TAKE_W'(1);
              emit_next           = 1'b1;
              second_pending_next = 1'b0;
            end else begin
              state_next = ST_IDLE;
            end
          end
        end
      end
      ST_ERR: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      kind           <= PK_KEEP;
      emit           <= 1'b0;
      t              <= '0;
      c              <= '0;
      take           <= TAKE_W'(1);
      second_pending <= 1'b0;
      second_c       <= '0;
      err_code       <= ERR_NONE;
      pair_short     <= 1'b0;
      count          <= LEN_W'(1);
    end else begin
      state          <= state_next;
      kind           <= kind_next;
      emit           <= emit_next;
      t              <= t_next;
      c              <= c_next;
      take           <= take_next;
      second_pending <= second_pending_next;
      second_c       <= second_c_next;
      err_code       <= err_code_next;
      pair_short     <= pair_short_next;
      count          <= count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_word || load_err) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_word) begin
      out_index <= t;
      out_entry <= feed;
      out_err   <= ERR_NONE;
      out_last  <= is_last;
    end else if (load_err) begin
      out_index <= '0;
      out_entry <= '0;
      out_err   <= err_code;
      out_last  <= 1'b1;
    end
  end

  assign m_tdata = {out_entry.length, out_entry.start, out_index};
  assign m_tuser = out_err;
  assign m_tlast = out_last;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (count >= LEN_W'(1)) && (count <= LEN_W'(MAX_ELEMS)))
    else $error("class count out of range");

  a_err_word: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != ERR_NONE)) |-> (m_tlast && (m_tdata == '0)))
    else $error("error word not a single cleared word");

  a_err_no_shift: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ERR) |-> !step)
    else $error("ring moved while reporting an error");

  a_count_growth: assert property (@(posedge clk) disable iff (rst)
    ($past(state) == ST_PASS && $past(kind) != PK_RESTART) |->
      ((count == $past(count)) || (count == LEN_W'($past(count) + LEN_W'(1)))))
    else $error("class count grew by more than one in a pass");

endmodule

// ----- tb/partition_individualize_tb.sv -----
// Self-checking testbench for partition_individualize: directed and random words on the
// input stream, class tables predicted in the bench and checked on the result stream.
// Depends on pi_pkg and the partition_individualize RTL.
`timescale 1ns / 1ps

module partition_individualize_tb;
  import pi_pkg::*;

  localparam int SETTLE_CYCLES = 80;
  localparam int STALL_LIMIT   = 4000;
  localparam int PRINT_LIMIT   = 20;

  typedef struct {
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] start;
    logic [LEN_W-1:0] len;
    err_t             err;
    logic             last;
  } class_word_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // class_a[4:0], class_b[9:5], zero
  logic [1:0]  s_tuser;   // action[1:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // class_index[4:0], class_start[9:5], class_length[15:10]
  logic [1:0]  m_tuser;   // error[1:0]
  logic        m_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [5:0]  cfg_data;

  // bench copy of the partition
  logic [LEN_W-1:0] part_start [MAX_ELEMS];
  logic [LEN_W-1:0] part_len   [MAX_ELEMS];
  int               part_count;
  logic [5:0]       elem_count;

  class_word_t table_queue [$];
  int          fail_count;
  int          quiet_cycles;
  bit          gaps_on;
  int          sink_stall;

  partition_individualize dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (fail_count < PRINT_LIMIT)
      $display("%0t mismatch: %s got %0d want %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic void restart_partition();
    int n;
    n = elem_count;
    if (n < 1) n = 1;
    if (n > MAX_ELEMS) n = MAX_ELEMS;
    for (int i = 0; i < MAX_ELEMS; i++) begin
      part_start[i] = '0;
      part_len[i]   = '0;
    end
    part_len[0] = LEN_W'(n);
    part_count  = 1;
  endfunction

  function automatic void split_classes(input int a, input int b, input bit pair);
    logic [LEN_W-1:0] ns [MAX_ELEMS];
    logic [LEN_W-1:0] nl [MAX_ELEMS];
    int cnt, f, l, take;
    bit sa, sb;
    cnt = 0;
    for (int i = 0; i < MAX_ELEMS; i++) begin
      ns[i] = '0;
      nl[i] = '0;
    end
    for (int i = 0; i < part_count && i < MAX_ELEMS; i++) begin
      f  = part_start[i];
      l  = part_len[i];
      sa = (i == a);
      sb = pair && (i == b);
      take = (sa && sb) ? 2 : ((sa || sb) ? 1 : 0);
      if (take > l) take = l;
      if (take > 0 && cnt < MAX_ELEMS) begin
        ns[cnt] = LEN_W'(f);
        nl[cnt] = LEN_W'(take);
        cnt++;
        f += take;
        l -= take;
      end
      if (l > 0 && cnt < MAX_ELEMS) begin
        ns[cnt] = LEN_W'(f);
        nl[cnt] = LEN_W'(l);
        cnt++;
      end
    end
    for (int i = 0; i < MAX_ELEMS; i++) begin
      part_start[i] = ns[i];
      part_len[i]   = nl[i];
    end
    part_count = cnt;
  endfunction

  // apply one input word to the bench partition and queue the words it should produce
  function automatic void predict_table(input act_t act, input int a, input int b);
    class_word_t w;
    err_t err;
    bit pair;
    int n;
    err  = ERR_NONE;
    pair = (act == ACT_TWO);
    case (act)
      ACT_RESTART: restart_partition();
      ACT_ONE, ACT_TWO: begin
        if (a >= part_count || (pair && b >= part_count))
          err = ERR_RANGE;
        else if (pair && a == b && part_len[a] < 2)
          err = ERR_PAIR;
        else
          split_classes(a, b, pair);
      end
      default: ;
    endcase
    if (err != ERR_NONE) begin
      w.idx = '0; w.start = '0; w.len = '0; w.err = err; w.last = 1'b1;
      table_queue.push_back(w);
    end else begin
      n = (part_count > MAX_ELEMS) ? MAX_ELEMS : part_count;
      for (int i = 0; i < n; i++) begin
        w.idx   = IDX_W'(i);
        w.start = part_start[i][IDX_W-1:0];
        w.len   = part_len[i];
        w.err   = ERR_NONE;
        w.last  = (i + 1 == n);
        table_queue.push_back(w);
      end
    end
  endfunction

  task automatic send_word(input act_t act, input logic [4:0] a, input logic [4:0] b);
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {6'd0, b, a};
    do @(posedge clk); while (!s_tready);
    predict_table(act, a, b);
    if (gaps_on && $urandom_range(3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (table_queue.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(input logic [5:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    elem_count = value;
  endtask

  task automatic test_reset_table();
    send_word(ACT_NOP, 5'd0, 5'd0);
    send_word(ACT_ONE, 5'd0, 5'd0);
    send_word(ACT_TWO, 5'd1, 5'd1);
    send_word(ACT_TWO, 5'd0, 5'd2);
    send_word(ACT_NOP, 5'd31, 5'd31);
  endtask

  task automatic test_bad_class();
    send_word(ACT_ONE, 5'd31, 5'd0);
    send_word(ACT_TWO, 5'd0, 5'd31);
    send_word(ACT_TWO, 5'd31, 5'd0);
    send_word(ACT_ONE, 5'(part_count), 5'd0);
    send_word(ACT_TWO, 5'd0, 5'd0);
  endtask

  task automatic test_count_limits();
    write_count(6'd1);
    send_word(ACT_RESTART, 5'd31, 5'd31);
    send_word(ACT_TWO, 5'd0, 5'd0);
    send_word(ACT_ONE, 5'd0, 5'd0);
    write_count(6'd2);
    send_word(ACT_RESTART, 5'd0, 5'd0);
    send_word(ACT_TWO, 5'd0, 5'd0);
    write_count(6'd0);
    send_word(ACT_RESTART, 5'd0, 5'd0);
    write_count(6'd63);
    send_word(ACT_RESTART, 5'd0, 5'd0);
    send_word(ACT_TWO, 5'd0, 5'd0);
    send_word(ACT_TWO, 5'd1, 5'd1);
  endtask

  task automatic test_random_refine(input logic [5:0] count, input int words);
    act_t act;
    logic [4:0] a, b;
    int r;
    write_count(count);
    send_word(ACT_RESTART, 5'($urandom), 5'($urandom));
    for (int k = 0; k < words; k++) begin
      r = $urandom_range(99);
      if (r < 4)       act = ACT_RESTART;
      else if (r < 8)  act = ACT_NOP;
      else if (r < 50) act = ACT_ONE;
      else             act = ACT_TWO;
      if ($urandom_range(9) == 0) begin
        a = 5'($urandom);
        b = 5'($urandom);
      end else begin
        a = 5'($urandom_range(part_count - 1));
        b = ($urandom_range(4) == 0) ? a : 5'($urandom_range(part_count - 1));
      end
      send_word(act, a, b);
    end
  endtask

  // result stream: sink stalls and checking
  always @(posedge clk) begin
    if (gaps_on && sink_stall == 0 && $urandom_range(4) == 0)
      sink_stall <= $urandom_range(3, 1);
    else if (sink_stall > 0)
      sink_stall <= sink_stall - 1;
    m_tready <= !(gaps_on && (sink_stall > 1 || (sink_stall == 0 && $urandom_range(4) == 0)));
  end

  always @(posedge clk) begin
    class_word_t w;
    if (!rst && m_tvalid && m_tready) begin
      if (table_queue.size() == 0) begin
        report_mismatch("unexpected word, class_index", m_tdata[4:0], -1);
      end else begin
        w = table_queue.pop_front();
        if (m_tdata[4:0] != w.idx)    report_mismatch("class_index", m_tdata[4:0], w.idx);
        if (m_tdata[9:5] != w.start)  report_mismatch("class_start", m_tdata[9:5], w.start);
        if (m_tdata[15:10] != w.len)  report_mismatch("class_length", m_tdata[15:10], w.len);
        if (m_tuser != w.err)         report_mismatch("error", m_tuser, w.err);
        if (m_tlast != w.last)        report_mismatch("last", m_tlast, w.last);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("partition_individualize verification failed");
      $finish;
    end
  end

  initial begin
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = '0;
    m_tready     = 1'b0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    fail_count   = 0;
    quiet_cycles = 0;
    sink_stall   = 0;
    gaps_on      = 1'b1;
    elem_count   = 6'd32;
    restart_partition();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_table();
    test_bad_class();
    test_count_limits();

    test_random_refine(6'd32, 48);
    test_random_refine(6'd1, 20);
    test_random_refine(6'd63, 48);
    test_random_refine(6'd0, 16);
    test_random_refine(6'($urandom_range(32, 1)), 48);
    test_random_refine(6'($urandom_range(32, 1)), 48);
    test_random_refine(6'($urandom_range(32, 1)), 48);
    test_random_refine(6'd2, 24);
    drain_results();
    gaps_on = 1'b0;
    test_random_refine(6'd32, 48);
    drain_results();

    if (table_queue.size() != 0)
      report_mismatch("words still expected", 0, table_queue.size());
    if (fail_count == 0) begin
      $display("partition_individualize verification clean");
    end else begin
      $display("partition_individualize verification failed");
    end
    $finish;
  end

endmodule
